// ----- rtl/lapf_pkg.sv -----
`default_nettype none

package lapf_pkg;

    localparam int MAX_LINE_WIDTH   = 1024;
    localparam int MAX_FRAME_HEIGHT = 1024;

    localparam int PIXEL_W     = 8;
    localparam int SIZE_W      = 11;
    localparam int COL_W       = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W       = $clog2(MAX_FRAME_HEIGHT);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SIZE_W;
    localparam int LINE_RAM_W  = 2 * PIXEL_W;

    localparam int OUT_QUEUE_DEPTH = 4;
    localparam int QPTR_W          = $clog2(OUT_QUEUE_DEPTH);
    localparam int QCNT_W          = QPTR_W + 1;

    // Eight neighbours minus eight times the centre, as a signed value.
    localparam int SUM_W = PIXEL_W + 4;

    localparam logic [SIZE_W-1:0]  MIN_SIZE   = SIZE_W'(3);
    localparam logic [PIXEL_W-1:0] PIXEL_MAX  = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_NEGATIVE_MODE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] edge_value;
        logic               frame_end;
    } out_item_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < MIN_SIZE) begin
            r = MIN_SIZE;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lapf_ram.sv -----
`default_nettype none

module lapf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/laplacian_3x3_edge_filter_top.sv -----
// Channel   Direction  Payload                      Handshake
// s_        in         lapf_pkg::in_item_t          s_valid / s_ready
// m_        out        lapf_pkg::out_item_t         m_valid / m_ready
// cfg_      in         index + 11-bit data          cfg_wr_en, no wait
//
// One pixel per cycle while s_ready is high; a result passes through the p1 and p2 registers and the queue.
// The line-store RAM is read on acceptance and written back in the following cycle.
// Reset clears the counters, window and output queue; the line stores are not cleared.
// A four-entry output queue absorbs stalls; s_ready falls only when it could overflow.
`default_nettype none

module laplacian_3x3_edge_filter_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire lapf_pkg::in_item_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output lapf_pkg::out_item_t                     m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [lapf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lapf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import lapf_pkg::*;

    logic [SIZE_W-1:0]  line_width_reg;
    logic [SIZE_W-1:0]  frame_height_reg;
    logic               negative_mode_reg;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic               p1_valid_reg, p1_emit_reg, p1_end_reg;
    logic [COL_W-1:0]   p1_addr_reg;
    logic [PIXEL_W-1:0] p1_pixel_reg;
    logic               p2_valid_reg, p2_end_reg;

    logic                  fwd_hit_reg, fwd_hit_next;
    logic [LINE_RAM_W-1:0] fwd_data_reg;

    logic [PIXEL_W-1:0] win_reg [9];
    logic [PIXEL_W-1:0] win_next [9];

    out_item_t          queue_reg [OUT_QUEUE_DEPTH];
    logic [QPTR_W-1:0]  q_wr_ptr_reg, q_rd_ptr_reg;
    logic [QCNT_W-1:0]  q_count_reg, in_flight;

    logic               s_accept, q_push, q_pop;
    logic [SIZE_W-1:0]  width_eff, height_eff, col_ext, row_ext;
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic               emit_cur, end_cur;

    logic [LINE_RAM_W-1:0] ram_rd_data, line_word, ram_wr_data;
    logic [PIXEL_W-1:0]    up_pix, mid_pix;

    logic [SUM_W-1:0]   nb_sum, diff, mag;
    logic [PIXEL_W-1:0] edge_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg    <= SIZE_W'(MAX_LINE_WIDTH);
            frame_height_reg  <= SIZE_W'(MAX_FRAME_HEIGHT);
            negative_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LINE_WIDTH:    line_width_reg    <= cfg_wdata;
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata;
                REG_NEGATIVE_MODE: negative_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign width_eff  = clamp_size(line_width_reg, SIZE_W'(MAX_LINE_WIDTH));
    assign height_eff = clamp_size(frame_height_reg, SIZE_W'(MAX_FRAME_HEIGHT));

    assign in_flight = q_count_reg + QCNT_W'(p1_valid_reg) + QCNT_W'(p2_valid_reg);
    assign s_ready   = in_flight < QCNT_W'(OUT_QUEUE_DEPTH);
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        col_cur  = s_data.frame_start ? '0 : col_reg;
        row_cur  = s_data.frame_start ? '0 : row_reg;
        col_ext  = SIZE_W'(col_cur);
        row_ext  = SIZE_W'(row_cur);
        emit_cur = (row_ext >= SIZE_W'(2)) && (col_ext >= SIZE_W'(2))
                   && (row_ext < height_eff) && (col_ext < width_eff);
        end_cur  = (row_ext == height_eff - SIZE_W'(1))
                   && (col_ext == width_eff - SIZE_W'(1));
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (col_ext + SIZE_W'(1) >= width_eff) begin
                col_next = '0;
                row_next = (row_ext + SIZE_W'(1) >= height_eff) ? '0 : row_cur + ROW_W'(1);
            end else begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    // Upper line in the high byte, middle line in the low byte.
    lapf_ram #(
        .WIDTH (LINE_RAM_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (ram_rd_data)
    );

    assign line_word    = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
    assign up_pix       = line_word[LINE_RAM_W-1:PIXEL_W];
    assign mid_pix      = line_word[PIXEL_W-1:0];
    assign ram_wr_data  = {mid_pix, p1_pixel_reg};
    assign fwd_hit_next = s_accept && p1_valid_reg && (p1_addr_reg == col_cur);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = up_pix;
        win_next[5] = mid_pix;
        win_next[8] = p1_pixel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            p1_valid_reg <= s_accept;
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
            fwd_hit_reg  <= fwd_hit_next;
            if (p1_valid_reg) begin
                for (int k = 0; k < 9; k++) begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_emit_reg  <= emit_cur;
            p1_end_reg   <= end_cur;
            p1_addr_reg  <= col_cur;
            p1_pixel_reg <= s_data.pixel;
        end
        fwd_data_reg <= ram_wr_data;
        p2_end_reg   <= p1_end_reg;
    end

    always_comb begin
        nb_sum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nb_sum = nb_sum + SUM_W'(win_reg[k]);
            end
        end
        diff = nb_sum - SUM_W'({win_reg[4], 3'b000});
        if (diff[SUM_W-1]) begin
            mag = negative_mode_reg ? (SUM_W'(0) - diff) : '0;
        end else begin
            mag = diff;
        end
        edge_value = (mag > SUM_W'(PIXEL_MAX)) ? PIXEL_MAX : mag[PIXEL_W-1:0];
    end

    assign q_push = p2_valid_reg;
    assign q_pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end else begin
            if (q_push) begin
                q_wr_ptr_reg <= q_wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                q_rd_ptr_reg <= q_rd_ptr_reg + QPTR_W'(1);
            end
            q_count_reg <= q_count_reg + QCNT_W'(q_push) - QCNT_W'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            queue_reg[q_wr_ptr_reg] <= '{edge_value: edge_value, frame_end: p2_end_reg};
        end
    end

    assign m_valid = q_count_reg != '0;
    assign m_data  = queue_reg[q_rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/lapf_checker.sv -----
`default_nettype none

module lapf_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire lapf_pkg::out_item_t                m_data
);

    // A waiting result item holds its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed or vanished while stalled");

    // After reset the block is empty and ready for an item.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // The input side stalls only while results are waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // A result item appearing from empty follows an item taken and passed through p1, p2 and the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3))
        else $error("result item without a matching input item");

endmodule

bind laplacian_3x3_edge_filter_top lapf_checker u_lapf_checker (.*);

`default_nettype wire
